FILE: sv/table_interp_binary_search_defines.svh
// Assertion macros shared by the table interpolation RTL.
// Included by tib_dp, the module that carries the concurrent assertions; no other dependencies.
`ifndef TABLE_INTERP_BINARY_SEARCH_DEFINES_SVH
`define TABLE_INTERP_BINARY_SEARCH_DEFINES_SVH
`ifndef SYNTHESIS
`define TIB_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("table interpolation assertion failed");
`define TIB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("table interpolation assertion failed");
`else
`define TIB_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define TIB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/tib_pkg.sv
// Shared types, constants and column decode functions for the table interpolator.
// No dependencies; imported by the controller, the datapath and the top level.
package tib_pkg;

	localparam int PIX_W     = 17;
	localparam int LOG_W     = 20;
	localparam int COL_W     = 21;
	localparam int WORD_W    = LOG_W + PIX_W;
	localparam int RES_W     = 20;
	localparam int SIZE_W    = 13;
	localparam int DIV_W     = 21;
	localparam int DIV_STEPS = DIV_W;
	localparam int CNT_W     = 5;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic             REQ_WRITE      = 1'b0;
	localparam logic             REQ_QUERY      = 1'b1;
	localparam logic [PADDR_W-1:0] REG_TABLE_SIZE = 3'd0;

	typedef logic [WORD_W-1:0]       tib_word_t;
	typedef logic signed [COL_W-1:0] tib_col_t;

	typedef struct packed {
		logic load;
		logic rd_first;
		logic rd_last;
		logic rd_mid;
		logic cap_first;
		logic chk;
		logic cmp;
		logic diff;
		logic mul;
		logic div;
		logic add;
		logic out_load;
	} tib_cmd_t;

	typedef struct packed {
		logic le_first;
		logic ge_last;
		logic mid_eq_lo;
		logic div_last;
	} tib_sts_t;

	// Entry word holds the log luminance in the upper bits and the pixel level below.
	function automatic tib_col_t col_pix(tib_word_t w);
		return {{(COL_W-PIX_W){1'b0}}, w[PIX_W-1:0]};
	endfunction

	function automatic tib_col_t col_log(tib_word_t w);
		return {{(COL_W-LOG_W){w[WORD_W-1]}}, w[WORD_W-1:PIX_W]};
	endfunction

	function automatic tib_col_t col_x(tib_word_t w, logic inv);
		return inv ? col_log(w) : col_pix(w);
	endfunction

	function automatic tib_col_t col_y(tib_word_t w, logic inv);
		return inv ? col_pix(w) : col_log(w);
	endfunction

endpackage

FILE: sv/tib_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies; holds the interpolation table entries.
module tib_ram #(
	parameter int WIDTH = 37,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

FILE: sv/tib_ctrl.sv
// Controller state machine sequencing clamp checks, binary search and division.
// Depends on tib_pkg for the command and status structs.
module tib_ctrl import tib_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_query,
	input  logic     out_free,
	input  tib_sts_t sts,
	output tib_cmd_t cmd,
	output logic     idle
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD0  = 4'd1;
	localparam logic [3:0] ST_RDN  = 4'd2;
	localparam logic [3:0] ST_CHK  = 4'd3;
	localparam logic [3:0] ST_SRCH = 4'd4;
	localparam logic [3:0] ST_CMP  = 4'd5;
	localparam logic [3:0] ST_DIFF = 4'd6;
	localparam logic [3:0] ST_MUL  = 4'd7;
	localparam logic [3:0] ST_DIV  = 4'd8;
	localparam logic [3:0] ST_ADD  = 4'd9;
	localparam logic [3:0] ST_DONE = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_query) begin
					cmd.load = 1'b1;
					state_d  = ST_RD0;
				end
			end
			ST_RD0: begin
				cmd.rd_first = 1'b1;
				state_d      = ST_RDN;
			end
			ST_RDN: begin
				cmd.rd_last   = 1'b1;
				cmd.cap_first = 1'b1;
				state_d       = ST_CHK;
			end
			ST_CHK: begin
				cmd.chk = 1'b1;
				state_d = (sts.le_first || sts.ge_last) ? ST_DONE : ST_SRCH;
			end
			ST_SRCH: begin
				if (sts.mid_eq_lo) begin
					state_d = ST_DIFF;
				end else begin
					cmd.rd_mid = 1'b1;
					state_d    = ST_CMP;
				end
			end
			ST_CMP: begin
				cmd.cmp = 1'b1;
				state_d = ST_SRCH;
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				if (sts.div_last) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				cmd.add = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign idle = (state_q == ST_IDLE);

endmodule

FILE: sv/tib_dp.sv
// Datapath: query registers, search bounds, bracket entries, multiplier and divider.
// Depends on tib_pkg and on the assertion macros in table_interp_binary_search_defines.svh.
`include "table_interp_binary_search_defines.svh"
module tib_dp import tib_pkg::*; #(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tib_cmd_t                       cmd,
	input  logic [SIZE_W-1:0]              table_size,
	input  logic signed [RES_W-1:0]        query_value,
	input  logic                           inverse,
	input  tib_word_t                      ram_rdata,
	output logic                           ram_re,
	output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr,
	output tib_sts_t                       sts,
	output logic signed [RES_W-1:0]        result_value,
	output logic                           clamped
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int NW = $clog2(TABLE_DEPTH + 1);

	tib_col_t          q_q;
	logic              inv_q;
	logic [NW-1:0]     n_q;
	logic [NW-1:0]     lo_q;
	logic [NW-1:0]     hi_q;
	logic [NW-1:0]     mid_q;
	tib_word_t         lo_w_q;
	tib_word_t         hi_w_q;
	logic              le_first_q;
	logic [DIV_W-1:0]  dx_q;
	logic [DIV_W-1:0]  d_q;
	logic [DIV_W-1:0]  mag_q;
	logic              neg_q;
	logic              zero_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RES_W-1:0]  res_q;
	logic              clamped_q;

	logic [31:0]          n_clip;
	logic [NW:0]          mid_sum;
	logic [NW-1:0]        mid;
	logic [NW-1:0]        n_last;
	tib_col_t             x_data;
	tib_col_t             y_data;
	tib_col_t             x_lo;
	tib_col_t             y_lo;
	tib_col_t             x_hi;
	tib_col_t             y_hi;
	tib_col_t             dy;
	tib_col_t             dx;
	tib_col_t             dstep;
	logic [2*DIV_W-1:0]   prod;
	logic [DIV_W:0]       trial;
	logic [DIV_W:0]       trial_sub;
	logic                 ge;
	logic signed [COL_W:0] quo_ext;
	logic signed [COL_W:0] quo_s;
	logic signed [COL_W:0] y_lo_ext;
	logic signed [COL_W:0] sum;

	always_comb begin
		if (table_size < SIZE_W'(2)) begin
			n_clip = 32'd2;
		end else if (32'(table_size) > 32'(TABLE_DEPTH)) begin
			n_clip = 32'(TABLE_DEPTH);
		end else begin
			n_clip = 32'(table_size);
		end
	end

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[NW:1];
	assign n_last  = n_q - NW'(1);

	assign ram_re = cmd.rd_first | cmd.rd_last | cmd.rd_mid;

	always_comb begin
		priority if (cmd.rd_first) begin
			ram_raddr = '0;
		end else if (cmd.rd_last) begin
			ram_raddr = n_last[AW-1:0];
		end else begin
			ram_raddr = mid[AW-1:0];
		end
	end

	assign x_data = col_x(ram_rdata, inv_q);
	assign y_data = col_y(ram_rdata, inv_q);
	assign x_lo   = col_x(lo_w_q, inv_q);
	assign y_lo   = col_y(lo_w_q, inv_q);
	assign x_hi   = col_x(hi_w_q, inv_q);
	assign y_hi   = col_y(hi_w_q, inv_q);

	assign dy    = y_hi - y_lo;
	assign dx    = q_q - x_lo;
	assign dstep = x_hi - x_lo;
	assign prod  = mag_q * dx_q;

	assign trial     = {rem_q, quo_q[DIV_W-1]};
	assign trial_sub = trial - {1'b0, d_q};
	assign ge        = (trial >= {1'b0, d_q});

	assign quo_ext  = {1'b0, quo_q};
	assign quo_s    = neg_q ? -quo_ext : quo_ext;
	assign y_lo_ext = {y_lo[COL_W-1], y_lo};
	assign sum      = y_lo_ext + quo_s;

	assign sts.le_first  = le_first_q;
	assign sts.ge_last   = (q_q >= x_data);
	assign sts.mid_eq_lo = (mid == lo_q);
	assign sts.div_last  = (cnt_q == CNT_W'(DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q  <= '0;
			hi_q  <= '0;
			mid_q <= '0;
			n_q   <= NW'(2);
			cnt_q <= '0;
		end else begin
			if (cmd.load) begin
				n_q <= NW'(n_clip);
			end
			if (cmd.chk) begin
				lo_q <= '0;
				hi_q <= n_q;
			end
			if (cmd.rd_mid) begin
				mid_q <= mid;
			end
			if (cmd.cmp) begin
				if (q_q < x_data) begin
					hi_q <= mid_q;
				end else begin
					lo_q <= mid_q;
				end
			end
			if (cmd.mul) begin
				cnt_q <= '0;
			end else if (cmd.div) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			q_q   <= {query_value[RES_W-1], query_value};
			inv_q <= inverse;
		end
		if (cmd.cap_first) begin
			lo_w_q     <= ram_rdata;
			le_first_q <= (q_q <= x_data);
		end
		if (cmd.chk) begin
			if (le_first_q) begin
				res_q     <= y_lo[RES_W-1:0];
				clamped_q <= 1'b1;
			end else if (sts.ge_last) begin
				res_q     <= y_data[RES_W-1:0];
				clamped_q <= 1'b1;
			end
		end
		if (cmd.cmp) begin
			if (q_q < x_data) begin
				hi_w_q <= ram_rdata;
			end else begin
				lo_w_q <= ram_rdata;
			end
		end
		if (cmd.diff) begin
			neg_q  <= dy[COL_W-1];
			mag_q  <= dy[COL_W-1] ? DIV_W'(-dy) : DIV_W'(dy);
			dx_q   <= DIV_W'(dx);
			d_q    <= DIV_W'(dstep);
			zero_q <= (x_hi == x_lo);
		end
		if (cmd.mul) begin
			rem_q <= prod[2*DIV_W-1:DIV_W];
			quo_q <= prod[DIV_W-1:0];
		end else if (cmd.div) begin
			rem_q <= ge ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
		if (cmd.add) begin
			res_q     <= zero_q ? y_lo[RES_W-1:0] : sum[RES_W-1:0];
			clamped_q <= 1'b0;
		end
	end

	assign result_value = res_q;
	assign clamped      = clamped_q;

	`TIB_ASSERT_IMPLY(a_probe_inside, clk, arst_n, cmd.cmp, (lo_q < mid_q) && (mid_q < hi_q))
	`TIB_ASSERT_IMPLY(a_hi_in_table, clk, arst_n, cmd.rd_mid, hi_q <= n_q)
	`TIB_ASSERT_IMPLY(a_div_bound, clk, arst_n, cmd.div, cnt_q < CNT_W'(DIV_STEPS))
	`TIB_ASSERT_NEXT(a_div_start, clk, arst_n, cmd.mul, cnt_q == '0)

endmodule

FILE: sv/table_interp_binary_search.sv
// Channel   Direction  Carries
// s_*       in         table write (tuser 0) or query (tuser 1)
// m_*       out        one interpolated result per query
// APB       in/out     table_size register at byte address 0
// A query that is clamped at an end entry skips the search and the division; otherwise
// each search probe is a read of the single-port table RAM plus a compare, and the
// divider yields one bit a cycle.
// Reset clears the control state and sets table_size to 2; table contents stay undefined.
// A finished result waits in the output register while the next item is taken; a query
// whose result is ready holds until that register is free.
// Top level of the table interpolator; depends on tib_pkg, tib_ram, tib_ctrl and tib_dp.
module table_interp_binary_search import tib_pkg::*; #(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	// entry_index[11:0], entry_pixel[28:12], entry_log_lum[48:29], inverse[49],
	// query_value[69:50], zero fill [71:70]
	input  logic [71:0]        s_tdata,
	// req_type[0]
	input  logic               s_tuser,
	output logic               m_tvalid,
	input  logic               m_tready,
	// result_value[19:0], clamped[20], zero fill [23:21]
	output logic [23:0]        m_tdata,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int AW = $clog2(TABLE_DEPTH);

	tib_cmd_t                cmd;
	tib_sts_t                sts;
	logic                    idle;
	logic                    in_acc;
	logic                    in_query;
	logic                    out_free;
	logic                    ram_we;
	logic                    ram_re;
	logic [AW-1:0]           ram_addr;
	logic [AW-1:0]           dp_raddr;
	tib_word_t               ram_rdata;
	tib_word_t               ram_wdata;
	logic [SIZE_W-1:0]       table_size_q;
	logic                    m_tvalid_q;
	logic [RES_W-1:0]        out_res_q;
	logic                    out_clamped_q;
	logic signed [RES_W-1:0] dp_res;
	logic                    dp_clamped;
	logic [11:0]             entry_index;
	logic [PIX_W-1:0]        entry_pixel;
	logic [LOG_W-1:0]        entry_log_lum;
	logic                    inverse;
	logic signed [RES_W-1:0] query_value;
	logic                    cfg_we;

	assign entry_index   = s_tdata[11:0];
	assign entry_pixel   = s_tdata[28:12];
	assign entry_log_lum = s_tdata[48:29];
	assign inverse       = s_tdata[49];
	assign query_value   = s_tdata[69:50];

	assign s_tready = idle;
	assign in_acc   = s_tvalid & s_tready;
	assign in_query = s_tvalid & (s_tuser == REQ_QUERY);
	assign out_free = !m_tvalid_q || m_tready;

	assign ram_we    = in_acc && (s_tuser == REQ_WRITE) && (32'(entry_index) < 32'(TABLE_DEPTH));
	assign ram_addr  = ram_we ? AW'(entry_index) : dp_raddr;
	assign ram_wdata = {entry_log_lum, entry_pixel};

	tib_ram #(
		.WIDTH (WORD_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	tib_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_query (in_query),
		.out_free (out_free),
		.sts      (sts),
		.cmd      (cmd),
		.idle     (idle)
	);

	tib_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.table_size   (table_size_q),
		.query_value  (query_value),
		.inverse      (inverse),
		.ram_rdata    (ram_rdata),
		.ram_re       (ram_re),
		.ram_raddr    (dp_raddr),
		.sts          (sts),
		.result_value (dp_res),
		.clamped      (dp_clamped)
	);

	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite & pready;
	assign prdata = (paddr == REG_TABLE_SIZE) ? PDATA_W'(table_size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= SIZE_W'(2);
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_we && (paddr == REG_TABLE_SIZE)) begin
				table_size_q <= pwdata[SIZE_W-1:0];
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_res_q     <= dp_res;
			out_clamped_q <= dp_clamped;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, out_clamped_q, out_res_q};

endmodule
